/* src/assert_macros.svh */
// Concurrent assertion helpers, sampled on the rising clock edge.
// Checks are disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Invariant check: expr must hold at every sampled edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`endif

/* src/ppu_pkg.sv */
package ppu_pkg;

	localparam int BYTE_W    = 8;
	localparam int RAW_W     = 16;
	localparam int DISP_W    = 24;
	localparam int MODE_W    = 3;
	localparam int PHASE_W   = 3;
	localparam int HELD_N    = 4;
	localparam int HELD_IDX_W = 2;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam int M_DATA_W  = RAW_W + DISP_W;

	localparam logic [APB_ADDR_W-1:0] ADDR_PIXEL_MODE = 2'd0;

	typedef enum logic [MODE_W-1:0] {
		MODE_MONO8      = 3'd0,
		MODE_MONO16     = 3'd1,
		MODE_RGB24      = 3'd2,
		MODE_VMONO10    = 3'd3,
		MODE_MONO12P    = 3'd4,
		MODE_VMONO12    = 3'd5,
		MODE_MONO10P    = 3'd6
	} pixel_mode_t;

	typedef struct packed {
		logic                pixel_valid;
		logic [RAW_W-1:0]    raw_value;
		logic [DISP_W-1:0]   display_value;
		logic                last_of_frame;
	} pixel_result_t;

	function automatic logic [PHASE_W-1:0] group_length(input logic [MODE_W-1:0] mode);
		logic [PHASE_W-1:0] len;
		unique case (mode)
			MODE_MONO16:  len = 3'd2;
			MODE_RGB24,
			MODE_VMONO10,
			MODE_MONO12P,
			MODE_VMONO12: len = 3'd3;
			MODE_MONO10P: len = 3'd5;
			default:      len = 3'd1;
		endcase
		return len;
	endfunction

endpackage

/* src/packed_pixel_unpacker.sv */
// Channel   Dir  Width  Contents (low bit up)
// s_*       in   8      tdata: data_byte; tlast: frame_end
// m_*       out  40     tdata: raw_value, display_value; tuser: pixel_valid;
//                       tlast: last_of_frame
// apb       in   32     register 0 at byte address 0: pixel_mode
//
// One byte per clock sustained while the output is not stalled; an accepted byte
// is registered in the input register, its result then in the result register.
// The byte path advances one register per cycle unless a result is stalled; bytes
// that finish no pixel and end no frame pass through without waiting on the output.
// Reset clears the mode, the group phase and both valid registers.
// A stalled result holds the output register and backs up into the input register.
module packed_pixel_unpacker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ppu_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ppu_pkg::M_DATA_W-1:0]     m_tdata,   // [15:0] raw_value, [39:16] display_value
	output logic                             m_tuser,   // [0] pixel_valid
	output logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ppu_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ppu_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ppu_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import ppu_pkg::*;

	`include "assert_macros.svh"

	logic [MODE_W-1:0] pixel_mode;
	logic              mode_wr;
	logic              res_valid;
	logic              res_ready;
	pixel_result_t     res;

	ppu_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pixel_mode (pixel_mode),
		.mode_wr    (mode_wr)
	);

	ppu_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.pixel_mode (pixel_mode),
		.mode_wr    (mode_wr),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	ppu_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	`ASSERT_IMPLIES(a_nopix_is_last, clk, arst_n, m_tvalid && !m_tuser, m_tlast)
	`ASSERT_IMPLIES(a_nopix_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)
	`ASSERT_IMPLIES(a_gray_width, clk, arst_n, res_valid && res.pixel_valid && pixel_mode != MODE_RGB24, res.display_value[DISP_W-1:BYTE_W] == '0)

endmodule

/* src/ppu_apb_regs.sv */
module ppu_apb_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ppu_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ppu_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ppu_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [ppu_pkg::MODE_W-1:0]        pixel_mode,
	output logic                              mode_wr
);
	import ppu_pkg::*;

	logic [MODE_W-1:0] pixel_mode_q;

	assign pready  = 1'b1;
	assign mode_wr = psel & penable & pwrite & pready & (paddr == ADDR_PIXEL_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= MODE_MONO8;
		end else if (mode_wr) begin
			pixel_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_PIXEL_MODE) begin
			prdata = {{(APB_DATA_W-MODE_W){1'b0}}, pixel_mode_q};
		end
	end

	assign pixel_mode = pixel_mode_q;

endmodule

/* src/ppu_unpack.sv */
module ppu_unpack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ppu_pkg::BYTE_W-1:0]   s_tdata,
	input  logic                         s_tlast,
	input  logic [ppu_pkg::MODE_W-1:0]   pixel_mode,
	input  logic                         mode_wr,
	output logic                         res_valid,
	input  logic                         res_ready,
	output ppu_pkg::pixel_result_t       res
);
	import ppu_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                last_s1;

	logic [PHASE_W-1:0]  phase_q;
	logic [BYTE_W-1:0]   held_q [HELD_N];

	logic [PHASE_W-1:0]  len;
	logic [PHASE_W-1:0]  ph;
	logic [PHASE_W-1:0]  ph_inc;
	logic [PHASE_W-1:0]  ph_next;
	logic                pix;
	logic [11:0]         p;
	logic                shift4;
	logic [RAW_W-1:0]    raw;
	logic [DISP_W-1:0]   disp;
	logic                emit;
	logic                consume;
	logic [BYTE_W-1:0]   b;

	assign b      = byte_s1;
	assign len    = group_length(pixel_mode);
	assign ph     = (phase_q >= len) ? '0 : phase_q;
	assign ph_inc = ph + 3'd1;
	assign ph_next = (ph_inc >= len || last_s1) ? '0 : ph_inc;

	always_comb begin
		pix    = 1'b0;
		p      = '0;
		shift4 = 1'b0;
		raw    = '0;
		disp   = '0;
		unique case (pixel_mode)
			MODE_MONO16: begin
				pix  = (ph == 3'd1);
				raw  = {b, held_q[0]};
				disp = {16'd0, b};
			end
			MODE_RGB24: begin
				pix  = (ph == 3'd2);
				disp = {held_q[0], held_q[1], b};
			end
			MODE_VMONO10: begin
				pix = (ph == 3'd1) || (ph == 3'd2);
				p   = (ph == 3'd1) ? {2'd0, held_q[0], b[1:0]} : {2'd0, b, held_q[1][7:6]};
			end
			MODE_MONO12P: begin
				pix    = (ph == 3'd1) || (ph == 3'd2);
				shift4 = 1'b1;
				p      = (ph == 3'd1) ? {b[3:0], held_q[0]} : {b, held_q[1][7:4]};
			end
			MODE_VMONO12: begin
				pix    = (ph == 3'd1) || (ph == 3'd2);
				shift4 = 1'b1;
				p      = (ph == 3'd1) ? {held_q[0], b[3:0]} : {b, held_q[1][7:4]};
			end
			MODE_MONO10P: begin
				pix = (ph != 3'd0);
				case (ph)
					3'd1:    p = {2'd0, b[1:0], held_q[0]};
					3'd2:    p = {2'd0, b[3:0], held_q[1][7:2]};
					3'd3:    p = {2'd0, b[5:0], held_q[2][7:4]};
					default: p = {2'd0, b, held_q[3][7:6]};
				endcase
			end
			default: begin
				pix  = 1'b1;
				raw  = {8'd0, b};
				disp = {16'd0, b};
			end
		endcase
		if (pixel_mode == MODE_VMONO10 || pixel_mode == MODE_MONO12P ||
		    pixel_mode == MODE_VMONO12 || pixel_mode == MODE_MONO10P) begin
			raw  = {4'd0, p};
			disp = shift4 ? {16'd0, p[11:4]} : {16'd0, p[9:2]};
		end
	end

	assign emit      = valid_s1 & (pix | last_s1);
	assign consume   = valid_s1 & (~emit | res_ready);
	assign s_tready  = ~valid_s1 | consume;
	assign res_valid = emit;

	always_comb begin
		res.pixel_valid   = pix;
		res.raw_value     = pix ? raw : '0;
		res.display_value = pix ? disp : '0;
		res.last_of_frame = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (mode_wr) begin
				phase_q <= '0;
			end else if (consume) begin
				phase_q <= ph_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (consume && ph < 3'(HELD_N)) begin
			held_q[ph[HELD_IDX_W-1:0]] <= b;
		end
	end

endmodule

/* src/ppu_out_stage.sv */
module ppu_out_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             res_valid,
	output logic                             res_ready,
	input  ppu_pkg::pixel_result_t           res,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ppu_pkg::M_DATA_W-1:0]     m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import ppu_pkg::*;

	logic          valid_s2;
	pixel_result_t res_s2;

	assign res_ready = ~valid_s2 | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.display_value, res_s2.raw_value};
	assign m_tuser  = res_s2.pixel_valid;
	assign m_tlast  = res_s2.last_of_frame;

endmodule
